// File: design/lpp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lpp_pkg
// Types and constants for the lidar serial packet parser: framer phases,
// result kinds, the result record and the byte codes of both packet types.
// ---------------------------------------------------------------------------
package lpp_pkg;

	localparam int unsigned DEF_READINGS_PER_PACKET = 4;
	localparam int unsigned IMU_BYTES               = 12;

	localparam logic [7:0] BYTE_FILL     = 8'hFF;
	localparam logic [7:0] BYTE_SYNC     = 8'hFA;
	localparam logic [7:0] BYTE_IMU_SYNC = 8'hFB;
	localparam logic [7:0] BYTE_IMU_MARK = 8'hCD;
	localparam logic [7:0] INDEX_MIN     = 8'hA0;
	localparam logic [7:0] INDEX_MAX     = 8'hF9;

	// bit positions in the reading word
	localparam int unsigned BIT_WARN    = 14;
	localparam int unsigned BIT_INVALID = 15;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_IMU_MARK,
		PH_IMU_DATA,
		PH_INDEX,
		PH_SPEED_LO,
		PH_SPEED_HI,
		PH_READ_LO,
		PH_READ_HI,
		PH_SIG_LO,
		PH_SIG_HI,
		PH_CHK_LO,
		PH_CHK_HI
	} phase_t;

	typedef enum logic [2:0] {
		KIND_READING   = 3'd0,
		KIND_INVALID   = 3'd1,
		KIND_WARNING   = 3'd2,
		KIND_PKT_END   = 3'd3,
		KIND_BAD_INDEX = 3'd4,
		KIND_IMU       = 3'd5
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [8:0]  angle;
		logic [13:0] distance;
		logic [15:0] signal;
		logic [7:0]  error_code;
		logic [15:0] speed;
		logic        checksum_ok;
		logic        scan_done;
		logic [3:0]  imu_index;
		logic [7:0]  imu_value;
	} result_t;

endpackage
`default_nettype wire

// File: design/lidar_packet_parser.sv
// A result is registered into the output register, or into the skid stage while the output register is held.
// Throughput: one byte per cycle while in_stall is low; the framer state updates in a single pass.
// A one-entry skid stage behind the output register keeps input open while a
// result waits; input stalls only when both output and skid hold results.
// Reset (arst_n low, asynchronous) returns the framer to idle and clears all
// framer state and both valid flags; the output and skid data are not reset.
`default_nettype none
// ---------------------------------------------------------------------------
// lidar_packet_parser
// Byte-serial framer for lidar range packets and interleaved IMU packets.
// Emits readings, packet-end summaries, bad-index events and IMU bytes.
// ---------------------------------------------------------------------------
module lidar_packet_parser
	import lpp_pkg::*;
#(
	parameter int unsigned READINGS_PER_PACKET = DEF_READINGS_PER_PACKET
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       kind,
	output logic [8:0]       angle,
	output logic [13:0]      distance,
	output logic [15:0]      signal,
	output logic [7:0]       error_code,
	output logic [15:0]      speed,
	output logic             checksum_ok,
	output logic             scan_done,
	output logic [3:0]       imu_index,
	output logic [7:0]       imu_value
);

	localparam int unsigned SLOT_W = (READINGS_PER_PACKET > 1) ? $clog2(READINGS_PER_PACKET) : 1;

	phase_t              phase_q, phase_d;
	logic [6:0]          pkt_idx_q, pkt_idx_d;
	logic [6:0]          prev_idx_q, prev_idx_d;
	logic [15:0]         speed_q, speed_d;
	logic [15:0]         rd_word_q, rd_word_d;
	logic [7:0]          lo_hold_q, lo_hold_d;
	logic [SLOT_W-1:0]   slot_q, slot_d;
	logic [31:0]         acc_q, acc_d;
	logic [3:0]          imu_cnt_q, imu_cnt_d;

	logic                in_fire;
	logic                res_valid;
	result_t             res;
	logic [15:0]         word;
	logic [14:0]         chk;
	logic [11:0]         angle_full;
	logic [4:0]          imu_next;

	logic                out_valid_q, skid_valid_q;
	result_t             out_q, skid_q;

	assign in_stall = skid_valid_q;
	assign in_fire  = in_valid && !in_stall;

	assign word       = {in_byte, lo_hold_q};
	assign chk        = acc_q[14:0] + acc_q[29:15];
	assign angle_full = 12'(pkt_idx_q) * 12'(READINGS_PER_PACKET) + 12'(slot_q);
	assign imu_next   = 5'(imu_cnt_q) + 5'd1;

	always_comb begin
		phase_d    = phase_q;
		pkt_idx_d  = pkt_idx_q;
		prev_idx_d = prev_idx_q;
		speed_d    = speed_q;
		rd_word_d  = rd_word_q;
		lo_hold_d  = lo_hold_q;
		slot_d     = slot_q;
		acc_d      = acc_q;
		imu_cnt_d  = imu_cnt_q;
		res_valid  = 1'b0;
		res        = '0;

		// fill bytes are dropped outside the imu mark and payload phases
		if (phase_q == PH_IMU_MARK || phase_q == PH_IMU_DATA || in_byte != BYTE_FILL) begin
			case (phase_q)
				PH_IDLE: begin
					if (in_byte == BYTE_SYNC) begin
						phase_d = PH_INDEX;
					end else if (in_byte == BYTE_IMU_SYNC) begin
						phase_d = PH_IMU_MARK;
					end
				end
				PH_IMU_MARK: begin
					if (in_byte == BYTE_IMU_MARK) begin
						imu_cnt_d = '0;
						phase_d   = PH_IMU_DATA;
					end else begin
						phase_d = PH_IDLE;
					end
				end
				PH_IMU_DATA: begin
					res_valid     = 1'b1;
					res.kind      = KIND_IMU;
					res.imu_index = imu_cnt_q;
					res.imu_value = in_byte;
					if (imu_next >= 5'(IMU_BYTES)) begin
						imu_cnt_d = '0;
						phase_d   = PH_IDLE;
					end else begin
						imu_cnt_d = imu_next[3:0];
					end
				end
				PH_INDEX: begin
					if (in_byte >= INDEX_MIN && in_byte <= INDEX_MAX) begin
						pkt_idx_d = 7'(in_byte - INDEX_MIN);
						acc_d     = {16'd0, in_byte, BYTE_SYNC};
						phase_d   = PH_SPEED_LO;
					end else begin
						res_valid      = 1'b1;
						res.kind       = KIND_BAD_INDEX;
						res.error_code = in_byte;
						phase_d        = PH_IDLE;
					end
				end
				PH_SPEED_LO: begin
					lo_hold_d = in_byte;
					phase_d   = PH_SPEED_HI;
				end
				PH_SPEED_HI: begin
					speed_d = word;
					acc_d   = {acc_q[30:0], 1'b0} + {16'd0, word};
					slot_d  = '0;
					phase_d = PH_READ_LO;
				end
				PH_READ_LO: begin
					lo_hold_d = in_byte;
					phase_d   = PH_READ_HI;
				end
				PH_READ_HI: begin
					rd_word_d = word;
					acc_d     = {acc_q[30:0], 1'b0} + {16'd0, word};
					phase_d   = PH_SIG_LO;
				end
				PH_SIG_LO: begin
					lo_hold_d = in_byte;
					phase_d   = PH_SIG_HI;
				end
				PH_SIG_HI: begin
					acc_d     = {acc_q[30:0], 1'b0} + {16'd0, word};
					res_valid = 1'b1;
					// warning flag wins over invalid flag
					if (rd_word_q[BIT_WARN]) begin
						res.kind = KIND_WARNING;
					end else if (rd_word_q[BIT_INVALID]) begin
						res.kind       = KIND_INVALID;
						res.error_code = rd_word_q[7:0];
					end else begin
						res.kind = KIND_READING;
					end
					res.angle    = angle_full[8:0];
					res.distance = rd_word_q[13:0];
					res.signal   = word;
					if (32'(slot_q) + 32'd1 >= 32'(READINGS_PER_PACKET)) begin
						slot_d  = '0;
						phase_d = PH_CHK_LO;
					end else begin
						slot_d  = slot_q + 1'b1;
						phase_d = PH_READ_LO;
					end
				end
				PH_CHK_LO: begin
					lo_hold_d = in_byte;
					phase_d   = PH_CHK_HI;
				end
				PH_CHK_HI: begin
					res_valid       = 1'b1;
					res.kind        = KIND_PKT_END;
					res.speed       = speed_q;
					res.checksum_ok = (word == {1'b0, chk});
					res.scan_done   = (pkt_idx_q < prev_idx_q);
					prev_idx_d      = pkt_idx_q;
					phase_d         = PH_IDLE;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			pkt_idx_q  <= '0;
			prev_idx_q <= '0;
			speed_q    <= '0;
			rd_word_q  <= '0;
			lo_hold_q  <= '0;
			slot_q     <= '0;
			acc_q      <= '0;
			imu_cnt_q  <= '0;
		end else if (in_fire) begin
			phase_q    <= phase_d;
			pkt_idx_q  <= pkt_idx_d;
			prev_idx_q <= prev_idx_d;
			speed_q    <= speed_d;
			rd_word_q  <= rd_word_d;
			lo_hold_q  <= lo_hold_d;
			slot_q     <= slot_d;
			acc_q      <= acc_d;
			imu_cnt_q  <= imu_cnt_d;
		end
	end

	// output register with one-entry skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q  <= skid_valid_q || (in_fire && res_valid);
			skid_valid_q <= 1'b0;
		end else if (in_fire && res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (in_fire && res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = out_q.kind;
	assign angle       = out_q.angle;
	assign distance    = out_q.distance;
	assign signal      = out_q.signal;
	assign error_code  = out_q.error_code;
	assign speed       = out_q.speed;
	assign checksum_ok = out_q.checksum_ok;
	assign scan_done   = out_q.scan_done;
	assign imu_index   = out_q.imu_index;
	assign imu_value   = out_q.imu_value;

`ifndef SYNTHESIS
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a result while the output register is empty");

	a_imu_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IMU_DATA |-> 32'(imu_cnt_q) < 32'(IMU_BYTES))
		else $error("imu byte count beyond packet length");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_READ_LO || phase_q == PH_READ_HI || phase_q == PH_SIG_LO
		|| phase_q == PH_SIG_HI) |-> 32'(slot_q) < 32'(READINGS_PER_PACKET))
		else $error("reading slot beyond readings per packet");
`endif

endmodule
`default_nettype wire

// File: sim/lidar_result_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lidar_result_checker
// Watches both channels of the packet parser, frames every accepted byte in
// its own model of the parser and compares each result transfer, field by
// field, with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module lidar_result_checker
	import lpp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [7:0]  in_byte,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [2:0]  kind,
	input  wire logic [8:0]  angle,
	input  wire logic [13:0] distance,
	input  wire logic [15:0] signal,
	input  wire logic [7:0]  error_code,
	input  wire logic [15:0] speed,
	input  wire logic        checksum_ok,
	input  wire logic        scan_done,
	input  wire logic [3:0]  imu_index,
	input  wire logic [7:0]  imu_value,
	output int unsigned      mismatches,
	output int unsigned      results_pending
);

	localparam int unsigned REPORT_LIMIT = 10;

	// framer model
	phase_t      frame_phase;
	logic [6:0]  pkt_index;
	logic [6:0]  prev_index;
	logic [15:0] speed_word;
	logic [15:0] reading_word;
	logic [7:0]  low_hold;
	logic [1:0]  reading_slot;
	logic [31:0] csum_acc;
	logic [3:0]  imu_count;

	result_t     expected_results[$];
	int unsigned fail_total;

	function automatic void fold_word(input logic [15:0] w);
		csum_acc = (csum_acc << 1) + {16'h0000, w};
	endfunction

	// advances the framer by one byte; returns 1 when the byte yields a result
	function automatic bit frame_byte(input logic [7:0] b, output result_t r);
		logic [15:0] word;
		logic [17:0] folded;
		int unsigned angle_full;
		r = '0;
		frame_byte = 1'b0;
		// fill bytes are only data inside an imu packet
		if (frame_phase != PH_IMU_MARK && frame_phase != PH_IMU_DATA && b == BYTE_FILL)
			return 1'b0;
		case (frame_phase)
			PH_IDLE: begin
				if (b == BYTE_SYNC)
					frame_phase = PH_INDEX;
				else if (b == BYTE_IMU_SYNC)
					frame_phase = PH_IMU_MARK;
			end
			PH_IMU_MARK: begin
				if (b == BYTE_IMU_MARK) begin
					imu_count = '0;
					frame_phase = PH_IMU_DATA;
				end else begin
					frame_phase = PH_IDLE;
				end
			end
			PH_IMU_DATA: begin
				r.kind = KIND_IMU;
				r.imu_index = imu_count;
				r.imu_value = b;
				frame_byte = 1'b1;
				if (imu_count + 1 >= IMU_BYTES) begin
					imu_count = '0;
					frame_phase = PH_IDLE;
				end else begin
					imu_count = imu_count + 4'd1;
				end
			end
			PH_INDEX: begin
				if (b >= INDEX_MIN && b <= INDEX_MAX) begin
					pkt_index = 7'(b - INDEX_MIN);
					csum_acc = {16'h0000, b, BYTE_SYNC};
					frame_phase = PH_SPEED_LO;
				end else begin
					r.kind = KIND_BAD_INDEX;
					r.error_code = b;
					frame_byte = 1'b1;
					frame_phase = PH_IDLE;
				end
			end
			PH_SPEED_LO: begin
				low_hold = b;
				frame_phase = PH_SPEED_HI;
			end
			PH_SPEED_HI: begin
				speed_word = {b, low_hold};
				fold_word(speed_word);
				reading_slot = '0;
				frame_phase = PH_READ_LO;
			end
			PH_READ_LO: begin
				low_hold = b;
				frame_phase = PH_READ_HI;
			end
			PH_READ_HI: begin
				reading_word = {b, low_hold};
				fold_word(reading_word);
				frame_phase = PH_SIG_LO;
			end
			PH_SIG_LO: begin
				low_hold = b;
				frame_phase = PH_SIG_HI;
			end
			PH_SIG_HI: begin
				word = {b, low_hold};
				fold_word(word);
				// warning flag wins over invalid flag
				if (reading_word[BIT_WARN]) begin
					r.kind = KIND_WARNING;
				end else if (reading_word[BIT_INVALID]) begin
					r.kind = KIND_INVALID;
					r.error_code = reading_word[7:0];
				end else begin
					r.kind = KIND_READING;
				end
				angle_full = pkt_index * DEF_READINGS_PER_PACKET + reading_slot;
				r.angle = angle_full[8:0];
				r.distance = reading_word[13:0];
				r.signal = word;
				frame_byte = 1'b1;
				if (reading_slot + 1 >= DEF_READINGS_PER_PACKET) begin
					reading_slot = '0;
					frame_phase = PH_CHK_LO;
				end else begin
					reading_slot = reading_slot + 2'd1;
					frame_phase = PH_READ_LO;
				end
			end
			PH_CHK_LO: begin
				low_hold = b;
				frame_phase = PH_CHK_HI;
			end
			PH_CHK_HI: begin
				word = {b, low_hold};
				folded = {3'b000, csum_acc[14:0]} + {1'b0, csum_acc[31:15]};
				r.kind = KIND_PKT_END;
				r.speed = speed_word;
				r.checksum_ok = (word == {1'b0, folded[14:0]});
				r.scan_done = (pkt_index < prev_index);
				prev_index = pkt_index;
				frame_byte = 1'b1;
				frame_phase = PH_IDLE;
			end
			default: frame_phase = PH_IDLE;
		endcase
	endfunction

	function automatic string show(input result_t r);
		return $sformatf("kind %0d angle %0d dist %0d sig %0d err %0d spd %0d ok %0b scan %0b imu %0d/%0d",
			r.kind, r.angle, r.distance, r.signal, r.error_code, r.speed,
			r.checksum_ok, r.scan_done, r.imu_index, r.imu_value);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		result_t predicted;
		if (!arst_n) begin
			frame_phase = PH_IDLE;
			pkt_index = '0;
			prev_index = '0;
			speed_word = '0;
			reading_word = '0;
			low_hold = '0;
			reading_slot = '0;
			csum_acc = '0;
			imu_count = '0;
			expected_results.delete();
			fail_total = 0;
			mismatches <= 0;
			results_pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got.kind = kind_t'(kind);
				got.angle = angle;
				got.distance = distance;
				got.signal = signal;
				got.error_code = error_code;
				got.speed = speed;
				got.checksum_ok = checksum_ok;
				got.scan_done = scan_done;
				got.imu_index = imu_index;
				got.imu_value = imu_value;
				if (expected_results.size() == 0) begin
					fail_total++;
					if (fail_total <= REPORT_LIMIT)
						$display("%0t: result with nothing outstanding: %s", $time, show(got));
				end else begin
					want = expected_results.pop_front();
					if (got.kind !== want.kind || got.angle !== want.angle ||
							got.distance !== want.distance || got.signal !== want.signal ||
							got.error_code !== want.error_code || got.speed !== want.speed ||
							got.checksum_ok !== want.checksum_ok ||
							got.scan_done !== want.scan_done ||
							got.imu_index !== want.imu_index ||
							got.imu_value !== want.imu_value) begin
						fail_total++;
						if (fail_total <= REPORT_LIMIT) begin
							$display("%0t: result mismatch", $time);
							$display("  expected %s", show(want));
							$display("  actual   %s", show(got));
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (frame_byte(in_byte, predicted))
					expected_results.push_back(predicted);
			end
			mismatches <= fail_total;
			results_pending <= expected_results.size();
		end
	end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Drives the lidar packet parser with directed and random byte streams of
// lidar packets, imu packets, fill bytes and noise, with bursty input and a
// patterned output stall; the checker alongside predicts and compares.
// ---------------------------------------------------------------------------
module tb_top;
	import lpp_pkg::*;

	localparam int unsigned ITEM_TARGET  = 1800;
	localparam int unsigned LONG_HOLD    = 80;
	localparam int unsigned QUIET_LIMIT  = 4000;
	localparam int unsigned DRAIN_CYCLES = 16;

	typedef enum int unsigned {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_TOGGLE
	} stall_mode_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [7:0]  in_byte   = 8'h00;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [2:0]  kind;
	logic [8:0]  angle;
	logic [13:0] distance;
	logic [15:0] signal;
	logic [7:0]  error_code;
	logic [15:0] speed;
	logic        checksum_ok;
	logic        scan_done;
	logic [3:0]  imu_index;
	logic [7:0]  imu_value;

	int unsigned mismatches;
	int unsigned results_pending;

	bit          hold_req   = 1'b0;
	bit          hold_done  = 1'b0;
	int unsigned burst_left = 0;
	int unsigned bytes_sent = 0;
	logic [7:0]  seq_index  = INDEX_MIN;

	lidar_packet_parser u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.angle       (angle),
		.distance    (distance),
		.signal      (signal),
		.error_code  (error_code),
		.speed       (speed),
		.checksum_ok (checksum_ok),
		.scan_done   (scan_done),
		.imu_index   (imu_index),
		.imu_value   (imu_value)
	);

	lidar_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_byte         (in_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.kind            (kind),
		.angle           (angle),
		.distance        (distance),
		.signal          (signal),
		.error_code      (error_code),
		.speed           (speed),
		.checksum_ok     (checksum_ok),
		.scan_done       (scan_done),
		.imu_index       (imu_index),
		.imu_value       (imu_value),
		.mismatches      (mismatches),
		.results_pending (results_pending)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// any byte except fill
	function automatic logic [7:0] data_byte();
		return 8'($urandom_range(0, 254));
	endfunction

	// one transfer, preceded by a random gap when the current burst runs out
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: gap = 0;
				9:          gap = $urandom_range(10, 30);
				default:    gap = $urandom_range(1, 6);
			endcase
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		in_byte <= b;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0) @(posedge clk);
	endtask

	// slot_flags holds two flag bits per reading, slot 0 in the low bits
	task automatic send_lidar(input logic [7:0] idx, input logic [7:0] slot_flags,
			input bit csum_good, input int unsigned fill_pct);
		logic [15:0] words[$];
		logic [7:0]  pkt[$];
		logic [7:0]  hi;
		logic [31:0] acc;
		logic [17:0] folded;
		logic [15:0] chk;
		words.push_back({data_byte(), data_byte()});
		for (int s = 0; s < DEF_READINGS_PER_PACKET; s++) begin
			hi = {slot_flags[2*s +: 2], 6'($urandom_range(0, 63))};
			if (hi == BYTE_FILL)
				hi = 8'hFE;
			words.push_back({hi, data_byte()});
			words.push_back({data_byte(), data_byte()});
		end
		acc = {16'h0000, idx, BYTE_SYNC};
		foreach (words[i])
			acc = (acc << 1) + {16'h0000, words[i]};
		folded = {3'b000, acc[14:0]} + {1'b0, acc[31:15]};
		chk = {1'b0, folded[14:0]};
		if (!csum_good) begin
			chk = chk ^ 16'($urandom_range(1, 16'h7FFE));
			if (chk[7:0] == BYTE_FILL)
				chk[7:0] = 8'hFE;
		end
		pkt = {BYTE_SYNC, idx};
		foreach (words[i]) begin
			pkt.push_back(words[i][7:0]);
			pkt.push_back(words[i][15:8]);
		end
		pkt.push_back(chk[7:0]);
		pkt.push_back(chk[15:8]);
		foreach (pkt[i]) begin
			if ($urandom_range(1, 100) <= fill_pct)
				send_byte(BYTE_FILL);
			send_byte(pkt[i]);
		end
	endtask

	task automatic send_imu(input bit mark_ok);
		logic [7:0] b;
		send_byte(BYTE_IMU_SYNC);
		if (mark_ok) begin
			send_byte(BYTE_IMU_MARK);
			repeat (IMU_BYTES) begin
				b = ($urandom_range(0, 4) == 0) ? BYTE_FILL : 8'($urandom_range(0, 255));
				send_byte(b);
			end
		end else begin
			b = 8'($urandom_range(0, 255));
			if (b == BYTE_IMU_MARK)
				b = 8'h00;
			send_byte(b);
		end
	endtask

	task automatic send_bad_index();
		send_byte(BYTE_SYNC);
		if ($urandom_range(0, 1) == 0)
			send_byte(8'($urandom_range(0, INDEX_MIN - 1)));
		else
			send_byte(8'($urandom_range(INDEX_MAX + 1, BYTE_FILL - 1)));
	endtask

	initial begin : stimulus
		int unsigned pick;
		logic [7:0]  idx;
		logic [7:0]  b;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle bytes, imu packet without its mark, then a full imu packet
		send_byte(BYTE_FILL);
		send_byte(8'h00);
		send_byte(BYTE_IMU_MARK);
		send_byte(BYTE_IMU_SYNC);
		send_byte(8'h12);
		send_byte(BYTE_IMU_SYNC);
		send_byte(BYTE_IMU_MARK);
		send_byte(8'h00);
		send_byte(BYTE_FILL);
		send_byte(BYTE_SYNC);
		send_byte(BYTE_IMU_SYNC);
		send_byte(BYTE_IMU_MARK);
		send_byte(8'h80);
		send_byte(8'h7F);
		send_byte(8'h01);
		send_byte(8'hFE);
		send_byte(8'h55);
		send_byte(8'hAA);
		send_byte(BYTE_FILL);
		// index bytes just outside the range on both sides
		send_byte(BYTE_SYNC);
		send_byte(INDEX_MIN - 8'd1);
		send_byte(BYTE_SYNC);
		send_byte(INDEX_MAX + 8'd1);
		send_byte(BYTE_SYNC);
		send_byte(8'h00);
		// both flags, warning, invalid, plain reading; fill bytes inside
		send_lidar(INDEX_MAX, 8'b00_10_01_11, 1'b1, 30);
		// index wraps below the last one, checksum wrong
		send_lidar(INDEX_MIN, 8'h00, 1'b0, 0);
		send_lidar(INDEX_MIN + 8'd1, 8'($urandom), 1'b1, 0);
		wait_drained();

		// output held off while imu bytes keep coming, so the input backs up
		hold_req = 1'b1;
		repeat (4) send_imu(1'b1);

		while (bytes_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				idx = ($urandom_range(0, 4) != 0) ? seq_index
					: 8'($urandom_range(INDEX_MIN, INDEX_MAX));
				seq_index = (idx == INDEX_MAX) ? INDEX_MIN : idx + 8'd1;
				send_lidar(idx, 8'($urandom), $urandom_range(0, 6) != 0,
					($urandom_range(0, 2) == 0) ? 10 : 0);
			end else if (pick < 70) begin
				send_imu(1'b1);
			end else if (pick < 76) begin
				send_imu(1'b0);
			end else if (pick < 83) begin
				send_bad_index();
			end else if (pick < 91) begin
				repeat ($urandom_range(1, 4)) begin
					b = data_byte();
					if (b == BYTE_SYNC || b == BYTE_IMU_SYNC)
						b = 8'h00;
					send_byte(b);
				end
			end else begin
				// truncated packet: whatever follows is taken as its body
				send_byte(BYTE_SYNC);
				send_byte(8'($urandom_range(INDEX_MIN, INDEX_MAX)));
				repeat ($urandom_range(1, 15)) send_byte(data_byte());
			end
			if (bytes_sent > ITEM_TARGET / 2 && bytes_sent < ITEM_TARGET / 2 + 30)
				wait_drained();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && results_pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin : receiver
		stall_mode_t mode;
		int unsigned mode_left;
		mode = STALL_NONE;
		mode_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done = 1'b1;
				out_stall <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = stall_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					STALL_NONE:  out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default:     out_stall <= ~out_stall;
				endcase
			end
		end
	end

	// ends the run when no transfer happens on either side for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("TB_ERROR");
		$finish;
	end

endmodule

// File: sim.f
design/lpp_pkg.sv
design/lidar_packet_parser.sv
sim/lidar_result_checker.sv
sim/tb_top.sv
